/* hdl/frc_pkg.sv */
// frc_pkg: shared types, constants and helper functions for the FM
// operator routing compiler. No dependencies.
`timescale 1ns / 1ps

package frc_pkg;

  localparam int NumOps   = 5;
  localparam int NumJoins = 4;
  localparam int IdW      = 7;
  localparam int OpW      = 3;
  localparam int DepthW   = 3;
  localparam int CountW   = 3;
  localparam int ModsW    = NumOps * NumOps;
  localparam int DepthsW  = NumOps * DepthW;
  localparam int OrderW   = NumOps * OpW;

  // join choices, one base-3 digit per join
  localparam logic [1:0] JOIN_SERIES   = 2'd0;
  localparam logic [1:0] JOIN_PARALLEL = 2'd1;
  localparam logic [1:0] JOIN_FEEDBACK = 2'd2;

  typedef logic [NumJoins-1:0][1:0] digits_t;
  typedef logic [NumOps-1:0][NumOps-1:0] mods_t;
  typedef logic [NumOps-1:0][DepthW-1:0] depths_t;
  typedef logic [NumOps-1:0][OpW-1:0] order_t;

  typedef struct packed {
    logic [NumOps-1:0] carriers;
    logic [OpW-1:0]    primary;
  } cluster_t;

  typedef struct packed {
    cluster_t          up;
    logic              mod_en;
    logic [OpW-1:0]    mod_dst;
    logic [NumOps-1:0] mod_src;
    logic              fb_en;
  } join_res_t;

  // split a 7-bit id into its four low base-3 digits; upper part ignored
  function automatic digits_t base3_digits(logic [IdW-1:0] id);
    logic [2:0] q27;
    logic [6:0] r27;
    logic [4:0] r;
    logic [1:0] q9;
    logic [3:0] r9;
    logic [1:0] q3;
    digits_t    d;
    if (id >= 7'd108) q27 = 3'd4;
    else if (id >= 7'd81) q27 = 3'd3;
    else if (id >= 7'd54) q27 = 3'd2;
    else if (id >= 7'd27) q27 = 3'd1;
    else q27 = 3'd0;
    r27 = id - 7'(7'(q27) * 7'd27);
    r   = r27[4:0];
    if (r >= 5'd18) q9 = 2'd2;
    else if (r >= 5'd9) q9 = 2'd1;
    else q9 = 2'd0;
    r9 = 4'(r - 5'(5'(q9) * 5'd9));
    if (r9 >= 4'd6) q3 = 2'd2;
    else if (r9 >= 4'd3) q3 = 2'd1;
    else q3 = 2'd0;
    d[0] = 2'(r9 - 4'(4'(q3) * 4'd3));
    d[1] = q3;
    d[2] = q9;
    case (q27)
      3'd3:    d[3] = 2'd0;
      3'd4:    d[3] = 2'd1;
      default: d[3] = q27[1:0];
    endcase
    return d;
  endfunction

  function automatic cluster_t leaf(logic [OpW-1:0] op);
    cluster_t c;
    c.carriers = NumOps'(1) << op;
    c.primary  = op;
    return c;
  endfunction

  // one join of the tree; the modulation it adds is returned alongside
  function automatic join_res_t join_ops(logic [1:0] sel, cluster_t big, cluster_t sml);
    join_res_t r;
    case (sel)
      JOIN_PARALLEL: begin
        r.up.carriers = big.carriers | sml.carriers;
        r.up.primary  = big.primary;
        r.mod_en      = 1'b0;
        r.mod_dst     = sml.primary;
        r.mod_src     = big.carriers;
        r.fb_en       = 1'b0;
      end
      default: begin
        r.up      = sml;
        r.mod_en  = 1'b1;
        r.mod_dst = sml.primary;
        r.mod_src = big.carriers;
        r.fb_en   = (sel == JOIN_FEEDBACK);
      end
    endcase
    return r;
  endfunction

endpackage

/* hdl/frc_ifs.sv */
// frc_ifs: valid/ready channel interfaces for the routing compiler's
// request and result streams. Depends on frc_pkg.
`timescale 1ns / 1ps

interface frc_in_if import frc_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [IdW-1:0] algorithm_id;

  modport source(output valid, output algorithm_id, input ready);
  modport sink(input valid, input algorithm_id, output ready);
endinterface

interface frc_out_if import frc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NumOps-1:0]  carrier_mask;
  logic [CountW-1:0]  carrier_total;
  logic [ModsW-1:0]   modulator_masks;
  logic [DepthsW-1:0] op_depths;
  logic [OrderW-1:0]  exec_order;
  logic [OpW-1:0]     fb_target;

  modport source(output valid, output carrier_mask, output carrier_total,
                 output modulator_masks, output op_depths, output exec_order,
                 output fb_target, input ready);
  modport sink(input valid, input carrier_mask, input carrier_total,
               input modulator_masks, input op_depths, input exec_order,
               input fb_target, output ready);
endinterface

/* hdl/fm_operator_routing_compiler.sv */
// fm_operator_routing_compiler: four-stage pipeline that turns an FM
// algorithm number into operator routing. Depends on frc_pkg, frc_ifs.
`timescale 1ns / 1ps

// Usage
//   din  (sink):   one transaction carries algorithm_id, four base-3 join
//                  choices (series, parallel, feedback), low digit first.
//   dout (source): one transaction per request with carrier mask/count,
//                  per-operator modulator masks, depths, evaluation order
//                  and the feedback operator.
// Pipeline
//   S1 base-3 digit split, S2 tree joins (carriers, modulators, feedback
//   sites), S3 depth resolution, S4 evaluation order, feedback pick and
//   the output register that drives dout.
// Path: an accepted request is registered in S1, then in S2, S3 and S4; the S4 register drives dout.
// Throughput: one transaction per cycle while dout.ready is high; each stage takes new data when
//   it is empty or its successor takes its contents.
// Stall: with dout.ready low the S4 result holds; earlier stages keep
//   filling bubbles, and din.ready drops only once all four are full.
//   Nothing is dropped or repeated.
// Reset: rst (synchronous) clears all stage valid bits; the stage payload
//   registers are not reset.
module fm_operator_routing_compiler import frc_pkg::*; (
  input logic        clk,
  input logic        rst,
  frc_in_if.sink     din,
  frc_out_if.source  dout
);

  // stage valid bits and advance conditions
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !s4_valid || dout.ready;
  assign rdy3      = !s3_valid || rdy4;
  assign rdy2      = !s2_valid || rdy3;
  assign rdy1      = !s1_valid || rdy2;
  assign din.ready = rdy1;

  // stage payloads
  digits_t           s1_digits;
  logic [NumOps-1:0] s2_carriers, s3_carriers, s4_carriers;
  mods_t             s2_mods, s3_mods, s4_mods;
  logic [NumOps-1:0] s2_fb, s3_fb;
  depths_t           s3_depth, s4_depth;
  order_t            s4_order;
  logic [CountW-1:0] s4_count;
  logic [OpW-1:0]    s4_fb_op;

  // ---- S2 combinational: evaluate the fixed tree ----
  join_res_t         ja, jb, jc, jr;
  mods_t             mods_c;
  logic [NumOps-1:0] fb_c;

  always_comb begin
    ja = join_ops(s1_digits[2], leaf(3'd0), leaf(3'd1));
    jb = join_ops(s1_digits[1], ja.up, leaf(3'd2));
    jc = join_ops(s1_digits[3], leaf(3'd3), leaf(3'd4));
    jr = join_ops(s1_digits[0], jb.up, jc.up);
    mods_c = '0;
    fb_c   = '0;
    for (int i = 0; i < NumOps; i++) begin
      if (ja.mod_en && ja.mod_dst == OpW'(i)) mods_c[i] = mods_c[i] | ja.mod_src;
      if (jb.mod_en && jb.mod_dst == OpW'(i)) mods_c[i] = mods_c[i] | jb.mod_src;
      if (jc.mod_en && jc.mod_dst == OpW'(i)) mods_c[i] = mods_c[i] | jc.mod_src;
      if (jr.mod_en && jr.mod_dst == OpW'(i)) mods_c[i] = mods_c[i] | jr.mod_src;
      fb_c[i] = (ja.fb_en && ja.mod_dst == OpW'(i)) || (jb.fb_en && jb.mod_dst == OpW'(i)) ||
                (jc.fb_en && jc.mod_dst == OpW'(i)) || (jr.fb_en && jr.mod_dst == OpW'(i));
    end
  end

  // ---- S3 combinational: depths ----
  // Each operator modulates at most one other, so a parent pointer plus
  // a few relaxation steps gives the chain length to the carriers.
  logic [NumOps-1:0][OpW-1:0] par;
  logic [NumOps-1:0]          par_ok;
  depths_t                    dep [NumOps];

  always_comb begin
    for (int m = 0; m < NumOps; m++) begin
      par[m]    = '0;
      par_ok[m] = 1'b0;
      for (int i = NumOps - 1; i >= 0; i--) begin
        if (s2_mods[i][m]) begin
          par[m]    = OpW'(i);
          par_ok[m] = 1'b1;
        end
      end
      dep[0][m] = s2_carriers[m] ? DepthW'(1) : '0;
    end
    for (int t = 1; t < NumOps; t++) begin
      for (int m = 0; m < NumOps; m++) begin
        dep[t][m] = dep[t-1][m];
        if (!s2_carriers[m] && par_ok[m] && dep[t-1][par[m]] != '0)
          dep[t][m] = dep[t-1][par[m]] + DepthW'(1);
      end
    end
  end

  // ---- S4 combinational: order, feedback pick, carrier count ----
  logic [NumOps-1:0][OpW-1:0] rank;
  order_t                     order_c;
  logic [OpW-1:0]             fb_win;
  logic [OpW-1:0]             fb_op_c;
  logic                       win;

  always_comb begin
    for (int i = 0; i < NumOps; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NumOps; j++) begin
        if (j != i && (s3_depth[j] > s3_depth[i] ||
                       (s3_depth[j] == s3_depth[i] && j < i)))
          rank[i] = rank[i] + OpW'(1);
      end
    end
    for (int s = 0; s < NumOps; s++) begin
      order_c[s] = '0;
      for (int i = 0; i < NumOps; i++)
        if (rank[i] == OpW'(s)) order_c[s] = order_c[s] | OpW'(i);
    end
    // shallowest feedback site wins, lowest index breaks a tie
    fb_win = '0;
    for (int i = 0; i < NumOps; i++) begin
      win = s3_fb[i];
      for (int j = 0; j < NumOps; j++) begin
        if (j != i && s3_fb[j] && (s3_depth[j] < s3_depth[i] ||
                                   (s3_depth[j] == s3_depth[i] && j < i)))
          win = 1'b0;
      end
      if (win) fb_win = fb_win | OpW'(i);
    end
    fb_op_c = (s3_fb != '0) ? fb_win : order_c[0];
  end

  // ---- stage registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= din.valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy4) s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_digits <= base3_digits(din.algorithm_id);
    if (rdy2) begin
      s2_carriers <= jr.up.carriers;
      s2_mods     <= mods_c;
      s2_fb       <= fb_c;
    end
    if (rdy3) begin
      s3_carriers <= s2_carriers;
      s3_mods     <= s2_mods;
      s3_fb       <= s2_fb;
      s3_depth    <= dep[NumOps-1];
    end
    if (rdy4) begin
      s4_carriers <= s3_carriers;
      s4_count    <= CountW'($countones(s3_carriers));
      s4_mods     <= s3_mods;
      s4_depth    <= s3_depth;
      s4_order    <= order_c;
      s4_fb_op    <= fb_op_c;
    end
  end

  assign dout.valid           = s4_valid;
  assign dout.carrier_mask    = s4_carriers;
  assign dout.carrier_total   = s4_count;
  assign dout.modulator_masks = s4_mods;
  assign dout.op_depths       = s4_depth;
  assign dout.exec_order      = s4_order;
  assign dout.fb_target       = s4_fb_op;

  // ---- assertions ----
  // every operator is either a carrier or modulates something
  assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> ((s4_carriers | s4_mods[0] | s4_mods[1] | s4_mods[2] | s4_mods[3] |
                   s4_mods[4]) == {NumOps{1'b1}}))
    else $error("operator neither carrier nor modulator");

  assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (s4_count == CountW'($countones(s4_carriers))))
    else $error("carrier count mismatch");

  // a full S3 moves into S4 whenever S4 can take it
  assert property (@(posedge clk) disable iff (rst)
    (s3_valid && rdy4) |=> s4_valid)
    else $error("pipeline lost a transaction between S3 and S4");

  assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (s4_fb_op < OpW'(NumOps) && s4_depth[0] != '0 && s4_depth[4] != '0))
    else $error("feedback operator or depth out of range");

endmodule
